// ----- rtl/cnq_pkg.sv -----
// ----------------------------------------------------------------------------
// C-style name quoter package
// Shared constants, types and character helpers for the name quoter.
// ----------------------------------------------------------------------------
package cnq_pkg;

	// Name length limit and the saturating output count derived from it.
	localparam int MAX_NAME_LENGTH = 4096;
	localparam int LEN_FULL        = 4 * MAX_NAME_LENGTH + 2;
	localparam int LEN_CAP         = (LEN_FULL < 32767) ? LEN_FULL : 32767;
	localparam int LEN_W           = 15;

	// At most six output bytes per input byte: two quotes and an octal escape.
	localparam int RUN_MAX = 6;
	localparam int RUN_W   = 3;
	localparam int BODY_MAX = 4;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_QUOTE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ADD_QUOTES = 2'd1;

	// Character codes.
	localparam logic [7:0] CHAR_DQUOTE = 8'h22;
	localparam logic [7:0] CHAR_BSLASH = 8'h5c;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_CTRL_END = 8'h20;
	localparam logic [7:0] CHAR_DEL    = 8'o177;
	localparam logic [7:0] CHAR_NUL    = 8'h00;

	// Running state of the name being quoted.
	typedef struct packed {
		logic [LEN_W-1:0] out_count;
		logic             quote_seen;
		logic             stopped_at_nul;
	} cnq_state_t;

	// One input byte worth of results, handed from the encoder to the serializer.
	typedef struct packed {
		logic [RUN_MAX-1:0][7:0] chars;
		logic [RUN_W-1:0]        npend;
		logic [RUN_W-1:0]        nres;
		logic                    last;
		logic                    needs_quote;
		logic [LEN_W-1:0]        length;
	} cnq_run_t;

	// Letter of a single-character backslash escape; valid flags a match.
	function automatic logic [8:0] esc_letter(input logic [7:0] ch);
		logic [8:0] r;
		begin
			unique case (ch)
				8'h07: r = {1'b1, 8'h61};
				8'h08: r = {1'b1, 8'h62};
				8'h0c: r = {1'b1, 8'h66};
				8'h0a: r = {1'b1, 8'h6e};
				8'h0d: r = {1'b1, 8'h72};
				8'h09: r = {1'b1, 8'h74};
				8'h0b: r = {1'b1, 8'h76};
				CHAR_BSLASH: r = {1'b1, CHAR_BSLASH};
				CHAR_DQUOTE: r = {1'b1, CHAR_DQUOTE};
				default: r = {1'b0, 8'h00};
			endcase
			return r;
		end
	endfunction

endpackage

// ----- rtl/cnq_encode.sv -----
// ----------------------------------------------------------------------------
// C-style name quoter encoder
// Turns one input byte and the running name state into the run of output
// bytes it causes, plus the next state of the name.
// ----------------------------------------------------------------------------
module cnq_encode (
	input  logic [7:0]          in_byte,
	input  logic                first_of_name,
	input  logic                last_of_name,
	input  logic                full_quote,
	input  logic                add_quotes,
	input  cnq_pkg::cnq_state_t state,
	output cnq_pkg::cnq_state_t state_next,
	output cnq_pkg::cnq_run_t   run
);
	import cnq_pkg::*;

	logic                         open_q;
	logic                         close_q;
	logic                         stopped_eff;
	logic                         process;
	logic                         esc;
	logic [8:0]                   letter;
	logic [BODY_MAX-1:0][7:0]     body;
	logic [RUN_W-1:0]             body_n;
	logic [RUN_W-1:0]             npend;
	logic [LEN_W-1:0]             count_base;
	logic [LEN_W:0]               count_sum;
	logic [LEN_W-1:0]             count_new;
	logic                         quote_new;
	logic                         stopped_new;
	logic [RUN_W-1:0]             rel;

	always_comb begin
		open_q      = first_of_name & add_quotes;
		close_q     = last_of_name & add_quotes;
		stopped_eff = first_of_name ? 1'b0 : state.stopped_at_nul;
		process     = !stopped_eff && (in_byte != CHAR_NUL);
		esc         = (in_byte < CHAR_CTRL_END) || (in_byte == CHAR_DQUOTE) ||
			(in_byte == CHAR_BSLASH) || (full_quote && (in_byte >= CHAR_DEL));
		letter      = esc_letter(in_byte);

		body   = '0;
		body_n = '0;
		if (process) begin
			if (!esc) begin
				body[0] = in_byte;
				body_n  = RUN_W'(1);
			end else if (letter[8]) begin
				body[0] = CHAR_BSLASH;
				body[1] = letter[7:0];
				body_n  = RUN_W'(2);
			end else begin
				body[0] = CHAR_BSLASH;
				body[1] = CHAR_ZERO | {6'b0, in_byte[7:6]};
				body[2] = CHAR_ZERO | {5'b0, in_byte[5:3]};
				body[3] = CHAR_ZERO | {5'b0, in_byte[2:0]};
				body_n  = RUN_W'(4);
			end
		end
	end

	// Place the opening quote, the body and the closing quote in order.
	always_comb begin
		run.chars = '0;
		for (int j = 0; j < RUN_MAX; j++) begin
			rel = RUN_W'(j) - {{(RUN_W-1){1'b0}}, open_q};
			if (open_q && (j == 0)) begin
				run.chars[j] = CHAR_DQUOTE;
			end else if (rel < body_n) begin
				run.chars[j] = body[rel[1:0]];
			end else if ((rel == body_n) && close_q) begin
				run.chars[j] = CHAR_DQUOTE;
			end
		end
	end

	always_comb begin
		npend = body_n + {{(RUN_W-1){1'b0}}, open_q} + {{(RUN_W-1){1'b0}}, close_q};
		count_base = first_of_name ? '0 : state.out_count;
		count_sum  = {1'b0, count_base} + {{(LEN_W+1-RUN_W){1'b0}}, npend};
		count_new  = (count_sum > (LEN_W+1)'(LEN_CAP)) ? LEN_W'(LEN_CAP)
			: count_sum[LEN_W-1:0];
		quote_new   = (first_of_name ? 1'b0 : state.quote_seen) | (process & esc);
		stopped_new = stopped_eff | (in_byte == CHAR_NUL);

		run.npend       = npend;
		run.nres        = (last_of_name && (npend == '0)) ? RUN_W'(1) : npend;
		run.last        = last_of_name;
		run.needs_quote = quote_new;
		run.length      = count_new;

		if (last_of_name) begin
			state_next = '0;
		end else begin
			state_next.out_count      = count_new;
			state_next.quote_seen     = quote_new;
			state_next.stopped_at_nul = stopped_new;
		end
	end

endmodule

// ----- rtl/cnq_serializer.sv -----
// ----------------------------------------------------------------------------
// C-style name quoter serializer
// Holds the run of one input byte and hands it out one word per cycle
// through the output register while the output is not stalled.
// ----------------------------------------------------------------------------
module cnq_serializer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  cnq_pkg::cnq_run_t run,
	output logic              busy_next_free,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_char,
	output logic              char_valid,
	output logic              run_last,
	output logic              name_done,
	output logic              needs_quote,
	output logic [14:0]       quoted_length
);
	import cnq_pkg::*;

	logic [RUN_MAX-1:0][7:0] run_chars_q;
	logic [RUN_W-1:0]        run_npend_q;
	logic [RUN_W-1:0]        run_nres_q;
	logic                    run_last_q;
	logic                    run_quote_q;
	logic [LEN_W-1:0]        run_len_q;
	logic [RUN_W-1:0]        run_idx_q;
	logic                    run_busy_q;
	logic                    out_valid_q;
	logic                    out_load;
	logic                    fin;
	logic                    done;

	assign out_load = run_busy_q && (!out_valid_q || !out_stall);
	assign fin      = (run_idx_q == (run_nres_q - RUN_W'(1)));
	assign done     = fin && run_last_q;

	// The run register frees up in the cycle its final word moves out.
	assign busy_next_free = !run_busy_q || (out_load && fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_busy_q <= 1'b0;
			run_idx_q  <= '0;
		end else if (load) begin
			run_busy_q <= 1'b1;
			run_idx_q  <= '0;
		end else if (out_load) begin
			if (fin) begin
				run_busy_q <= 1'b0;
			end
			run_idx_q <= run_idx_q + RUN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			run_chars_q <= run.chars;
			run_npend_q <= run.npend;
			run_nres_q  <= run.nres;
			run_last_q  <= run.last;
			run_quote_q <= run.needs_quote;
			run_len_q   <= run.length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			char_valid    <= (run_idx_q < run_npend_q);
			out_char      <= (run_idx_q < run_npend_q) ? run_chars_q[run_idx_q] : 8'h00;
			run_last      <= fin;
			name_done     <= done;
			needs_quote   <= done & run_quote_q;
			quoted_length <= (done && run_quote_q) ? run_len_q : '0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/c_style_name_quoter_core.sv -----
// ----------------------------------------------------------------------------
// C-style name quoter core
// Streams the bytes of a name and returns its C-style quoted form.
// ----------------------------------------------------------------------------
// Each accepted input word is one byte of a name, marked as the first and/or
// last byte. The encoder turns it in the cycle of acceptance into a run of
// zero to six output words (opening quote, the byte or its escape, closing
// quote), which the serializer hands out through the output register at one
// word per cycle while the output is not stalled. A run holds one word for a
// plain byte, two for a backslash escape, four for an octal escape, plus one
// for each quote; a byte with no output (a byte after a NUL, for instance)
// does not load the run register and only updates the name state. The next
// input word is accepted in the same cycle that the last word of the current
// run moves to the output register, so the output register keeps streaming
// without gaps while the consumer takes words. The final output word of a
// name carries the summary: whether any byte needed escaping and, if so, the
// emitted length with quotes, saturating at 16386. A last-marked byte with
// nothing to emit still yields one word with char_valid low to carry that
// summary. The two configuration registers (full_quote, add_quotes) reset to
// one and should be written only while the block is idle; writes to unknown
// indexes are ignored.
// ----------------------------------------------------------------------------
module c_style_name_quoter_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [cnq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic                             cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       in_byte,
	input  logic                             first_of_name,
	input  logic                             last_of_name,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [7:0]                       out_char,
	output logic                             char_valid,
	output logic                             run_last,
	output logic                             name_done,
	output logic                             needs_quote,
	output logic [14:0]                      quoted_length
);
	import cnq_pkg::*;

	logic       full_quote_q;
	logic       add_quotes_q;
	cnq_state_t state_q;
	cnq_state_t state_next;
	cnq_run_t   run;
	logic       in_accept;
	logic       run_free;
	logic       run_load;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_quote_q <= 1'b1;
			add_quotes_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FULL_QUOTE: full_quote_q <= cfg_data;
				REG_ADD_QUOTES: add_quotes_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// An input word is taken whenever the run register is free or freeing.
	assign in_stall  = !run_free;
	assign in_accept = in_valid && run_free;
	// Words that cause no output do not occupy the run register.
	assign run_load  = in_accept && (run.nres != '0);

	cnq_encode u_encode (
		.in_byte       (in_byte),
		.first_of_name (first_of_name),
		.last_of_name  (last_of_name),
		.full_quote    (full_quote_q),
		.add_quotes    (add_quotes_q),
		.state         (state_q),
		.state_next    (state_next),
		.run           (run)
	);

	// Name state: length so far, escape seen, and NUL seen.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (in_accept) begin
			state_q <= state_next;
		end
	end

	cnq_serializer u_serializer (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (run_load),
		.run            (run),
		.busy_next_free (run_free),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_char       (out_char),
		.char_valid     (char_valid),
		.run_last       (run_last),
		.name_done      (name_done),
		.needs_quote    (needs_quote),
		.quoted_length  (quoted_length)
	);

endmodule

// ----- rtl/cnq_checker.sv -----
// ----------------------------------------------------------------------------
// C-style name quoter checker
// Port-level checks on the output word stream, bound to the core.
// ----------------------------------------------------------------------------
module cnq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  out_char,
	input logic        char_valid,
	input logic        run_last,
	input logic        name_done,
	input logic        needs_quote,
	input logic [14:0] quoted_length
);

	// A stalled output word stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_char) &&
		$stable(char_valid) && $stable(run_last) && $stable(name_done) &&
		$stable(quoted_length))
		else $error("output word changed while stalled");

	// A word without a byte only exists to carry the name summary.
	a_empty_is_summary: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !char_valid |-> name_done && run_last)
		else $error("empty output word outside a name summary");

	// The name summary closes the run of its input word.
	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && name_done |-> run_last)
		else $error("name summary not on the last word of a run");

	// Summary fields are zero except on the final word of a name.
	a_summary_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !name_done |-> !needs_quote && (quoted_length == 15'd0))
		else $error("summary fields set outside a name summary");

	// A name that needed no escaping reports zero length; one that did has
	// at least a backslash and one more byte.
	a_length_rule: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && name_done |->
		(!needs_quote && (quoted_length == 15'd0)) ||
		(needs_quote && (quoted_length >= 15'd2)))
		else $error("quoted length inconsistent with escape flag");

endmodule

bind c_style_name_quoter_core cnq_checker u_cnq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.out_char      (out_char),
	.char_valid    (char_valid),
	.run_last      (run_last),
	.name_done     (name_done),
	.needs_quote   (needs_quote),
	.quoted_length (quoted_length)
);
